// ----- design/tss_pkg.sv -----
// Shared widths, register indexes and reset values for the turn-signal sequencer.
`default_nettype none
package tss_pkg;

   localparam int TIME_W  = 32;
   localparam int PIXEL_W = 16;
   localparam int COLOR_W = 24;
   localparam int COUNT_W = PIXEL_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COLOR_W;

   localparam logic [CSR_IDX_W-1:0] REG_START_PIXEL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_PIXEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_MS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAUSE_MS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIT_COLOR   = 3'd4;

   localparam logic [PIXEL_W-1:0] START_PIXEL_RESET = 16'd0;
   localparam logic [PIXEL_W-1:0] END_PIXEL_RESET   = 16'd7;
   localparam logic [PIXEL_W-1:0] STEP_MS_RESET     = 16'd25;
   localparam logic [PIXEL_W-1:0] PAUSE_MS_RESET    = 16'd1000;
   localparam logic [COLOR_W-1:0] LIT_COLOR_RESET   = 24'hFF4500;

endpackage
`default_nettype wire

// ----- design/tss_if.sv -----
// Request and response channel interfaces of the turn-signal sequencer.
`default_nettype none
interface tss_req_if
   import tss_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output now_ms, input ready);
   modport sink   (input valid, input now_ms, output ready);
endinterface

interface tss_rsp_if
   import tss_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               is_clear;
   logic [PIXEL_W-1:0] pixel_index;
   logic [COLOR_W-1:0] pixel_value;

   modport source (output valid, output is_clear, output pixel_index, output pixel_value,
                   input ready);
   modport sink   (input valid, input is_clear, input pixel_index, input pixel_value,
                   output ready);
endinterface
`default_nettype wire

// ----- design/sequential_turn_signal_sequencer_top.sv -----
// Top level of the sequential turn-signal sequencer.
// A request that causes a pixel write or strip clear shows it on rsp in the next cycle.
// Throughput: one request per cycle; the output register lets a new request enter while
// the previous response is still waiting, as long as that response is taken in the same cycle.
// Reset (synchronous, active high) restores the register defaults and clears all counters,
// timestamps and the response valid.
`default_nettype none
module sequential_turn_signal_sequencer_top
   import tss_pkg::*;
   (
   input  wire                   clock,
   input  wire                   reset,
   tss_req_if.sink               req_chan,
   tss_rsp_if.source             rsp_chan,
   input  wire                   csr_we,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata
   );

   logic [PIXEL_W-1:0] start_ff, end_ff, step_ms_ff, pause_ms_ff;
   logic [COLOR_W-1:0] color_ff;

   logic [COUNT_W-1:0] lit_ff, lit_in, dark_ff, dark_in;
   logic [TIME_W-1:0]  last_step_ff, last_step_in, last_pause_ff, last_pause_in;
   logic               pause_done_ff, pause_done_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_clear_ff, rsp_clear_in;
   logic [PIXEL_W-1:0] rsp_index_ff, rsp_index_in;
   logic [COLOR_W-1:0] rsp_value_ff, rsp_value_in;

   logic               accept, emit, reverse, step_elapsed, pause_elapsed;
   logic [PIXEL_W-1:0] span, map_k;
   logic [COUNT_W-1:0] count;
   logic [TIME_W-1:0]  step_age, pause_age;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.is_clear    = rsp_clear_ff;
   assign rsp_chan.pixel_index = rsp_index_ff;
   assign rsp_chan.pixel_value = rsp_value_ff;

   always_comb begin
      reverse       = start_ff > end_ff;
      span          = reverse ? (start_ff - end_ff) : (end_ff - start_ff);
      count         = {1'b0, span} + {{(COUNT_W-1){1'b0}}, 1'b1};
      step_age      = req_chan.now_ms - last_step_ff;
      pause_age     = req_chan.now_ms - last_pause_ff;
      step_elapsed  = step_age >= {{(TIME_W-PIXEL_W){1'b0}}, step_ms_ff};
      pause_elapsed = pause_age >= {{(TIME_W-PIXEL_W){1'b0}}, pause_ms_ff};

      lit_in        = lit_ff;
      dark_in       = dark_ff;
      last_step_in  = last_step_ff;
      last_pause_in = last_pause_ff;
      pause_done_in = pause_done_ff;
      emit          = 1'b0;
      rsp_clear_in  = 1'b0;
      rsp_value_in  = '0;
      map_k         = '0;

      if (lit_ff < count) begin
         // Lighting phase: one pixel per elapsed step interval.
         map_k = lit_ff[PIXEL_W-1:0];
         if (step_elapsed) begin
            emit         = 1'b1;
            rsp_value_in = color_ff;
            lit_in       = lit_ff + {{(COUNT_W-1){1'b0}}, 1'b1};
            last_step_in = req_chan.now_ms;
         end
      end else if (dark_ff < count) begin
         // Hold the full sweep for one pause, then turn pixels off one per request.
         map_k = dark_ff[PIXEL_W-1:0];
         if (!pause_done_ff) begin
            if (pause_elapsed) begin
               last_pause_in = req_chan.now_ms;
               pause_done_in = 1'b1;
            end
         end else begin
            emit    = 1'b1;
            dark_in = dark_ff + {{(COUNT_W-1){1'b0}}, 1'b1};
         end
      end else if (pause_elapsed) begin
         last_pause_in = req_chan.now_ms;
         lit_in        = '0;
         dark_in       = '0;
         pause_done_in = 1'b0;
         emit          = 1'b1;
         rsp_clear_in  = 1'b1;
      end

      if (rsp_clear_in) begin
         rsp_index_in = '0;
      end else begin
         rsp_index_in = reverse ? (start_ff - map_k) : (start_ff + map_k);
      end

      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= START_PIXEL_RESET;
         end_ff      <= END_PIXEL_RESET;
         step_ms_ff  <= STEP_MS_RESET;
         pause_ms_ff <= PAUSE_MS_RESET;
         color_ff    <= LIT_COLOR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_START_PIXEL: start_ff    <= csr_wdata[PIXEL_W-1:0];
            REG_END_PIXEL:   end_ff      <= csr_wdata[PIXEL_W-1:0];
            REG_STEP_MS:     step_ms_ff  <= csr_wdata[PIXEL_W-1:0];
            REG_PAUSE_MS:    pause_ms_ff <= csr_wdata[PIXEL_W-1:0];
            REG_LIT_COLOR:   color_ff    <= csr_wdata[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff        <= '0;
         dark_ff       <= '0;
         last_step_ff  <= '0;
         last_pause_ff <= '0;
         pause_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            lit_ff        <= lit_in;
            dark_ff       <= dark_in;
            last_step_ff  <= last_step_in;
            last_pause_ff <= last_pause_in;
            pause_done_ff <= pause_done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_clear_ff <= rsp_clear_in;
         rsp_index_ff <= rsp_index_in;
         rsp_value_ff <= rsp_value_in;
      end
   end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the sequential turn-signal sequencer: polls, register writes, checks.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tss_pkg::*;

   typedef struct packed {
      logic               is_clear;
      logic [PIXEL_W-1:0] pixel_index;
      logic [COLOR_W-1:0] pixel_value;
   } strip_write_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tss_req_if req_chan ();
   tss_rsp_if rsp_chan ();

   sequential_turn_signal_sequencer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies and sweep state of the predictor.
   logic [PIXEL_W-1:0] cfg_start, cfg_end, cfg_step_ms, cfg_pause_ms;
   logic [COLOR_W-1:0] cfg_color;
   logic [COUNT_W-1:0] lit_count, dark_count;
   logic [TIME_W-1:0]  step_stamp, pause_stamp;
   logic               pause_done;

   strip_write_type   pending_writes[$];
   logic [TIME_W-1:0] poll_time = '0;
   int error_count = 0;
   int request_count = 0;
   int result_count = 0;
   int clear_count = 0;
   int write_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 40) $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   task automatic clear_sweep_state();
      cfg_start    = START_PIXEL_RESET;
      cfg_end      = END_PIXEL_RESET;
      cfg_step_ms  = STEP_MS_RESET;
      cfg_pause_ms = PAUSE_MS_RESET;
      cfg_color    = LIT_COLOR_RESET;
      lit_count    = '0;
      dark_count   = '0;
      step_stamp   = '0;
      pause_stamp  = '0;
      pause_done   = 1'b0;
   endtask

   function automatic logic [COUNT_W-1:0] sweep_length();
      logic [PIXEL_W-1:0] span;
      span = (cfg_start > cfg_end) ? cfg_start - cfg_end : cfg_end - cfg_start;
      return {1'b0, span} + COUNT_W'(1);
   endfunction

   function automatic logic [PIXEL_W-1:0] strip_index(input logic [COUNT_W-1:0] k);
      if (cfg_start > cfg_end) return cfg_start - k[PIXEL_W-1:0];
      return cfg_start + k[PIXEL_W-1:0];
   endfunction

   // The pause timer restamps itself whenever it reports the interval as elapsed.
   function automatic bit pause_over(input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] gone;
      gone = now - pause_stamp;
      if (gone >= TIME_W'(cfg_pause_ms)) begin
         pause_stamp = now;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit poll_sequencer(input logic [TIME_W-1:0] now,
                                         output strip_write_type wr);
      logic [COUNT_W-1:0] n;
      logic [TIME_W-1:0]  gone;
      n = sweep_length();
      wr = '0;
      gone = now - step_stamp;
      if (lit_count < n) begin
         if (gone < TIME_W'(cfg_step_ms)) return 1'b0;
         wr.pixel_index = strip_index(lit_count);
         wr.pixel_value = cfg_color;
         lit_count++;
         step_stamp = now;
         return 1'b1;
      end
      if (dark_count < n) begin
         if (!pause_done) begin
            pause_done = pause_over(now);
            return 1'b0;
         end
         wr.pixel_index = strip_index(dark_count);
         dark_count++;
         return 1'b1;
      end
      if (!pause_over(now)) return 1'b0;
      lit_count   = '0;
      dark_count  = '0;
      pause_done  = 1'b0;
      wr.is_clear = 1'b1;
      return 1'b1;
   endfunction

   function automatic logic [TIME_W-1:0] next_poll_time();
      int unsigned scale;
      int          pick;
      scale = ((cfg_step_ms > cfg_pause_ms) ? cfg_step_ms : cfg_pause_ms) / 4 + 2;
      pick = $urandom_range(99);
      if (pick < 88) poll_time += $urandom_range(0, scale);
      else if (pick < 95) poll_time = $urandom();
      else poll_time -= $urandom_range(0, scale);
      return poll_time;
   endfunction

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_START_PIXEL: cfg_start    = value[PIXEL_W-1:0];
         REG_END_PIXEL:   cfg_end      = value[PIXEL_W-1:0];
         REG_STEP_MS:     cfg_step_ms  = value[PIXEL_W-1:0];
         REG_PAUSE_MS:    cfg_pause_ms = value[PIXEL_W-1:0];
         REG_LIT_COLOR:   cfg_color    = value[COLOR_W-1:0];
         default: ;
      endcase
      write_count++;
   endtask

   // A poll may leave nothing behind, so settle waits on the pending writes and then idles before it returns.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_poll(input logic [TIME_W-1:0] now);
      strip_write_type wr;
      int              gap;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid  <= 1'b1;
      req_chan.now_ms <= now;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      request_count++;
      if (poll_sequencer(now, wr)) pending_writes.push_back(wr);
   endtask

   task automatic randomize_registers(input bit every);
      int                 span;
      logic [PIXEL_W-1:0] s;
      int                 e;
      if (every || $urandom_range(1) == 0) begin
         case ($urandom_range(9))
            0:       s = '0;
            1:       s = '1;
            default: s = PIXEL_W'($urandom());
         endcase
         span = $urandom_range(0, 11);
         case ($urandom_range(9))
            0:       e = $urandom_range(0, 65535);
            1:       e = s;
            default: e = ($urandom_range(1) != 0) ? int'(s) + span : int'(s) - span;
         endcase
         if (e > 65535) e = 65535;
         if (e < 0) e = 0;
         set_register(REG_START_PIXEL, CSR_DATA_W'(s));
         set_register(REG_END_PIXEL, CSR_DATA_W'(e));
      end
      if (every || $urandom_range(1) == 0) begin
         case ($urandom_range(19))
            0, 1, 2: set_register(REG_STEP_MS, '0);
            3:       set_register(REG_STEP_MS, CSR_DATA_W'(16'hFFFF));
            default: set_register(REG_STEP_MS, CSR_DATA_W'($urandom_range(1, 40)));
         endcase
      end
      if (every || $urandom_range(1) == 0) begin
         case ($urandom_range(19))
            0, 1, 2: set_register(REG_PAUSE_MS, '0);
            3:       set_register(REG_PAUSE_MS, CSR_DATA_W'(16'hFFFF));
            default: set_register(REG_PAUSE_MS, CSR_DATA_W'($urandom_range(1, 300)));
         endcase
      end
      if (every || $urandom_range(1) == 0) begin
         case ($urandom_range(9))
            0:       set_register(REG_LIT_COLOR, '0);
            1:       set_register(REG_LIT_COLOR, '1);
            default: set_register(REG_LIT_COLOR, CSR_DATA_W'($urandom()));
         endcase
      end
   endtask

   always @(posedge clock) rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      strip_write_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         result_count++;
         if (pending_writes.size() == 0) begin
            flag_error($sformatf("unexpected strip write: clear %0b index %0d value %06h",
                                 rsp_chan.is_clear, rsp_chan.pixel_index,
                                 rsp_chan.pixel_value));
         end else begin
            want = pending_writes.pop_front();
            if (rsp_chan.is_clear !== want.is_clear)
               flag_error($sformatf("is_clear %b, expected %b",
                                    rsp_chan.is_clear, want.is_clear));
            if (rsp_chan.pixel_index !== want.pixel_index)
               flag_error($sformatf("pixel_index %0d, expected %0d",
                                    rsp_chan.pixel_index, want.pixel_index));
            if (rsp_chan.pixel_value !== want.pixel_value)
               flag_error($sformatf("pixel_value %06h, expected %06h",
                                    rsp_chan.pixel_value, want.pixel_value));
            if (want.is_clear) clear_count++;
         end
      end
   end

   // Reset values, then a register change in the middle of the lit phase.
   task automatic test_default_sweep();
      send_poll(24);
      send_poll(25);
      send_poll(49);
      send_poll(50);
      settle();
      set_register(REG_END_PIXEL, CSR_DATA_W'(1));
      send_poll(999);
      send_poll(1000);
      send_poll(1000);
      send_poll(1000);
      send_poll(1999);
      send_poll(2000);
   endtask

   task automatic test_reverse_zero_intervals();
      settle();
      set_register(REG_START_PIXEL, CSR_DATA_W'(3));
      set_register(REG_END_PIXEL, '0);
      set_register(REG_STEP_MS, '0);
      set_register(REG_PAUSE_MS, '0);
      set_register(REG_LIT_COLOR, '1);
      for (int i = 0; i < 10; i++) send_poll((i % 2 == 0) ? '1 : '0);
   endtask

   // Elapsed time across the 32-bit wrap, with the pause stamp shared by both waits.
   task automatic test_time_wrap();
      settle();
      set_register(REG_START_PIXEL, CSR_DATA_W'(16'hFFFF));
      set_register(REG_END_PIXEL, CSR_DATA_W'(16'hFFFF));
      set_register(REG_STEP_MS, CSR_DATA_W'(100));
      set_register(REG_PAUSE_MS, CSR_DATA_W'(100));
      set_register(REG_LIT_COLOR, '0);
      send_poll(32'hFFFF_FF9C);
      send_poll(32'h0000_0000);
      send_poll(32'h0000_0063);
      send_poll(32'h0000_0064);
      send_poll(32'h0000_00C8);
      send_poll(32'h0000_00C8);
   endtask

   // Writes to indexes past the last register must leave every register alone.
   task automatic test_unused_registers();
      settle();
      set_register(REG_STEP_MS, CSR_DATA_W'(16'hFFFF));
      set_register(REG_PAUSE_MS, CSR_DATA_W'(16'hFFFF));
      for (int i = REG_LIT_COLOR + 1; i < (1 << CSR_IDX_W); i++)
         set_register(CSR_IDX_W'(i), '1);
      poll_time = 32'h1000_0000;
      send_poll(poll_time);
      for (int i = 0; i < 4; i++) begin
         poll_time += (i % 2 == 0) ? 32'd65534 : 32'd65535;
         send_poll(poll_time);
      end
   endtask

   // Sets up sweeps over all 65536 pixels in both directions; a 16-bit pixel count would
   // see them as empty. Shrinking the sweep afterwards ends the lit phase at once.
   task automatic test_full_width();
      settle();
      set_register(REG_START_PIXEL, '0);
      set_register(REG_END_PIXEL, CSR_DATA_W'(16'hFFFF));
      set_register(REG_STEP_MS, '0);
      set_register(REG_PAUSE_MS, '0);
      set_register(REG_LIT_COLOR, CSR_DATA_W'($urandom()));
      repeat (16) send_poll($urandom());
      settle();
      set_register(REG_START_PIXEL, CSR_DATA_W'(16'hFFFF));
      set_register(REG_END_PIXEL, '0);
      repeat (8) send_poll($urandom());
      settle();
      set_register(REG_START_PIXEL, '0);
      set_register(REG_END_PIXEL, CSR_DATA_W'(2));
      repeat (6) send_poll($urandom());
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall, input int polls);
      settle();
      send_idle_pct = idle_pct;
      stall_pct = stall;
      randomize_registers(1'b1);
      for (int i = 0; i < polls; i++) begin
         if (i != 0 && $urandom_range(49) == 0) begin
            settle();
            randomize_registers(1'b0);
         end
         send_poll(next_poll_time());
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.now_ms = '0;
      clear_sweep_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_default_sweep();
      test_reverse_zero_intervals();
      test_time_wrap();
      test_unused_registers();
      test_full_width();
      test_random_traffic(0, 0, 450);
      test_random_traffic(81, 0, 450);
      test_random_traffic(0, 81, 450);
      test_random_traffic(9, 9, 450);
      settle();
      stall_pct = 0;
      $display("Run covered %0d poll requests, %0d strip writes (%0d strip clears),",
               request_count, result_count, clear_count);
      $display("%0d reg writes, 65536-pixel sweeps, time wrap and four idling mixes.",
               write_count);
      if (error_count == 0 && pending_writes.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
